// ===== hdl/dcmp_pkg.sv =====
// Shared types and constants for the DC motor encoder positioner.
`timescale 1ns / 1ps
`default_nettype none
package dcmp_pkg;

    localparam int PWM_PERIOD_DEF     = 400;
    localparam int BACKOFF_COUNTS_DEF = 2;
    localparam int DUTY_W             = 9;
    localparam int POS_W              = 32;
    localparam int COUNTS_W           = 24;

    localparam logic [DUTY_W-1:0] DUTY_RESET = 9'd30;

    localparam logic KIND_TICK = 1'b0;
    localparam logic KIND_MOVE = 1'b1;

    typedef struct packed {
        logic                    kind;
        logic signed [POS_W-1:0] encoder_position;
        logic [COUNTS_W-1:0]     move_counts;
        logic                    move_dir;
        logic                    move_back;
    } in_item_t;

    typedef struct packed {
        logic drive_in_pin;
        logic drive_out_pin;
        logic busy_res;
        logic reached;
        logic accepted;
    } out_item_t;

endpackage
`default_nettype wire

// ===== hdl/dc_motor_pwm_encoder_positioner_core.sv =====
// Top level of the DC motor encoder positioner with soft PWM drive.
// The accepted transaction waits in the input register; its result is registered
// into the result register once the output side is free, and m_valid then rises.
// Throughput: one transaction per cycle while m_ready is high, set by the single update pass per item.
// An input register and a result register part the two channels.
// Reset: synchronous, active low; phase 0, duty 30, idle, back-off pending,
// both drive pins low, both channel registers empty.
`timescale 1ns / 1ps
`default_nettype none
module dc_motor_pwm_encoder_positioner_core #(
    parameter int PWM_PERIOD     = dcmp_pkg::PWM_PERIOD_DEF,
    parameter int BACKOFF_COUNTS = dcmp_pkg::BACKOFF_COUNTS_DEF
) (
    input  wire                            aclk,
    input  wire                            aresetn,
    input  wire                            cfg_we,
    input  wire [dcmp_pkg::DUTY_W-1:0]     cfg_wdata,
    input  wire                            s_valid,
    output logic                           s_ready,
    input  wire dcmp_pkg::in_item_t        s_data,
    output logic                           m_valid,
    input  wire                            m_ready,
    output dcmp_pkg::out_item_t            m_data
);
    import dcmp_pkg::*;

    logic      in_valid_reg, in_valid_next;
    in_item_t  in_data_reg;
    logic      m_valid_reg, m_valid_next;
    out_item_t m_data_reg;
    out_item_t step_result;
    logic      advance;

    assign advance = in_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    always_comb begin
        if (s_valid && s_ready) begin
            in_valid_next = 1'b1;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end else begin
            in_valid_next = in_valid_reg;
        end
        if (advance) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    dcmp_ctrl #(
        .PWM_PERIOD     (PWM_PERIOD),
        .BACKOFF_COUNTS (BACKOFF_COUNTS)
    ) u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .step_en   (advance),
        .item      (in_data_reg),
        .result    (step_result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_data_reg <= s_data;
        end
        if (advance) begin
            m_data_reg <= step_result;
        end
    end

    a_one_pin_high: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> !(m_data_reg.drive_in_pin && m_data_reg.drive_out_pin))
        else $error("both drive pins high");

    a_reach_vs_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> !(m_data_reg.reached && m_data_reg.accepted))
        else $error("reached and accepted in one result");

    a_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_data_reg.accepted) |-> m_data_reg.busy_res)
        else $error("accepted move not busy");

    a_hold_pending: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && !advance) |=> (in_valid_reg && $stable(in_data_reg)))
        else $error("pending transaction lost");

    a_full_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && m_valid_reg && !m_ready) |-> !s_ready)
        else $error("ready while both stages full");

endmodule
`default_nettype wire

// ===== hdl/dcmp_ctrl.sv =====
// Positioner state, PWM phase and per-transaction update logic.
`timescale 1ns / 1ps
`default_nettype none
module dcmp_ctrl #(
    parameter int PWM_PERIOD     = dcmp_pkg::PWM_PERIOD_DEF,
    parameter int BACKOFF_COUNTS = dcmp_pkg::BACKOFF_COUNTS_DEF
) (
    input  wire                            aclk,
    input  wire                            aresetn,
    input  wire                            cfg_we,
    input  wire [dcmp_pkg::DUTY_W-1:0]     cfg_wdata,
    input  wire                            step_en,
    input  wire dcmp_pkg::in_item_t        item,
    output dcmp_pkg::out_item_t            result
);
    import dcmp_pkg::*;

    localparam int PHASE_W = $clog2(PWM_PERIOD);
    localparam int CMP_W   = (PHASE_W > DUTY_W) ? PHASE_W : DUTY_W;

    logic [DUTY_W-1:0]       duty_reg;
    logic [PHASE_W-1:0]      phase_reg, phase_next;
    logic signed [POS_W-1:0] target_reg, target_next;
    logic                    dir_reg, dir_next;
    logic                    running_reg, running_next;
    logic                    backoff_reg, backoff_next;
    logic                    in_pin_reg, in_pin_next;
    logic                    out_pin_reg, out_pin_next;

    logic [PHASE_W:0]        phase_inc;
    logic                    pwm_level;
    logic                    arrived;
    logic                    active_level;
    logic                    reached;
    logic                    accepted;

    always_comb begin
        phase_inc    = {1'b0, phase_reg} + (PHASE_W+1)'(1);
        phase_next   = phase_reg;
        target_next  = target_reg;
        dir_next     = dir_reg;
        running_next = running_reg;
        backoff_next = backoff_reg;
        in_pin_next  = in_pin_reg;
        out_pin_next = out_pin_reg;
        reached      = 1'b0;
        accepted     = 1'b0;
        pwm_level    = 1'b0;
        arrived      = 1'b0;
        active_level = 1'b0;

        if (item.kind == KIND_MOVE) begin
            if (!running_reg) begin
                accepted     = 1'b1;
                running_next = 1'b1;
                dir_next     = item.move_dir;
                backoff_next = item.move_back;
                if (item.move_dir) begin
                    target_next = item.encoder_position
                                  + $signed({8'b0, item.move_counts});
                end else begin
                    target_next = item.encoder_position
                                  - $signed({8'b0, item.move_counts});
                end
            end
        end else begin
            if (phase_inc >= (PHASE_W+1)'(PWM_PERIOD)) begin
                phase_next = '0;
            end else begin
                phase_next = phase_inc[PHASE_W-1:0];
            end
            if (running_reg) begin
                pwm_level = CMP_W'(phase_next) < CMP_W'(duty_reg);
                arrived   = dir_reg ? (item.encoder_position >= target_reg)
                                    : (target_reg >= item.encoder_position);
                active_level = arrived ? 1'b0 : pwm_level;
                if (dir_reg) begin
                    out_pin_next = active_level;
                end else begin
                    in_pin_next = active_level;
                end
                if (arrived) begin
                    reached      = 1'b1;
                    running_next = 1'b0;
                    if (backoff_reg) begin
                        backoff_next = 1'b0;
                        running_next = 1'b1;
                        dir_next     = !dir_reg;
                        if (dir_reg) begin
                            target_next = item.encoder_position
                                          - $signed(POS_W'(BACKOFF_COUNTS));
                        end else begin
                            target_next = item.encoder_position
                                          + $signed(POS_W'(BACKOFF_COUNTS));
                        end
                    end
                end
            end
        end

        result.drive_in_pin  = in_pin_next;
        result.drive_out_pin = out_pin_next;
        result.busy_res      = running_next;
        result.reached       = reached;
        result.accepted      = accepted;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            duty_reg <= DUTY_RESET;
        end else if (cfg_we) begin
            duty_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= '0;
            target_reg  <= '0;
            dir_reg     <= 1'b0;
            running_reg <= 1'b0;
            backoff_reg <= 1'b1;
            in_pin_reg  <= 1'b0;
            out_pin_reg <= 1'b0;
        end else if (step_en) begin
            phase_reg   <= phase_next;
            target_reg  <= target_next;
            dir_reg     <= dir_next;
            running_reg <= running_next;
            backoff_reg <= backoff_next;
            in_pin_reg  <= in_pin_next;
            out_pin_reg <= out_pin_next;
        end
    end

endmodule
`default_nettype wire
